// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and defaults for the sorted priority queue
package spq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int OCC_W = 5;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		opcode_t            opcode;
		logic signed [31:0] entry_data;
		logic signed [31:0] entry_priority;
	} req_word_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] removed_data;
		logic signed [31:0] removed_priority;
		logic [OCC_W-1:0]   occupancy;
	} rsp_word_t;

	typedef struct packed {
		logic signed [31:0] data;
		logic signed [31:0] prio;
	} entry_t;

	typedef struct packed {
		logic enq;
		logic deq;
	} cell_ctrl_t;

endpackage

// ----- rtl/sorted_priority_queue.sv -----
`timescale 1ns / 1ps
// sorted priority queue: top level with the cell chain and output skid
//
// req channel carries one word: opcode, entry_data, entry_priority.
// rsp channel returns one word per request: status, removed_data,
// removed_priority and the occupancy after the request.
// an enqueue lands ahead of every stored entry with priority >= its own,
// so equal priorities leave newest first; a dequeue returns the smallest.
// every cell compares against the new word and shifts in the same
// cycle, and the result is registered; throughput is one word per
// cycle while rsp is taken.
// a two-deep output stage (register plus skid) lets one more request in
// while a result is stalled; req_stall rises only when both are full.
// enqueue to a full queue answers ST_FULL, dequeue of an empty queue
// answers ST_EMPTY, both leave the queue unchanged with zero data.
// reset (arst_n low) empties the queue and drops pending results at once;
// no clearing pass is needed since slots past the count are never read.
module sorted_priority_queue #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  spq_pkg::req_word_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output spq_pkg::rsp_word_t rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             full;
	logic             empty;
	logic             accept;
	logic             out_fire;
	logic             out_valid_q;
	logic             skid_valid_q;
	spq_pkg::rsp_word_t out_q;
	spq_pkg::rsp_word_t skid_q;
	spq_pkg::rsp_word_t result;
	spq_pkg::cell_ctrl_t ctrl;
	spq_pkg::entry_t   new_entry;
	spq_pkg::entry_t   ent [CAPACITY];
	logic              ge  [CAPACITY];
	logic [CNT_W+spq_pkg::OCC_W-1:0] occ_ext;

	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);
	assign req_stall = skid_valid_q;
	assign accept   = req_valid && !req_stall;
	assign out_fire = out_valid_q && !rsp_stall;

	assign ctrl.enq = accept && (req.opcode == spq_pkg::OP_ENQ) && !full;
	assign ctrl.deq = accept && (req.opcode == spq_pkg::OP_DEQ) && !empty;

	assign new_entry.data = req.entry_data;
	assign new_entry.prio = req.entry_priority;

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			spq_pkg::entry_t left_entry;
			spq_pkg::entry_t right_entry;
			logic            left_ge;
			logic            occupied;

			assign occupied = (CNT_W'(i) < count_q);
			if (i == 0) begin : g_first
				assign left_entry = '0;
				assign left_ge    = 1'b0;
			end else begin : g_mid
				assign left_entry = ent[i-1];
				assign left_ge    = ge[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign right_entry = ent[i];
			end else begin : g_inner
				assign right_entry = ent[i+1];
			end

			spq_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.occupied    (occupied),
				.new_entry   (new_entry),
				.left_entry  (left_entry),
				.left_ge     (left_ge),
				.right_entry (right_entry),
				.entry       (ent[i]),
				.ge          (ge[i])
			);
		end
	endgenerate

	always_comb begin
		count_next = count_q;
		if (ctrl.enq) begin
			count_next = count_q + 1'b1;
		end else if (ctrl.deq) begin
			count_next = count_q - 1'b1;
		end
		occ_ext = {{spq_pkg::OCC_W{1'b0}}, count_next};
		result.occupancy        = occ_ext[spq_pkg::OCC_W-1:0];
		result.status           = spq_pkg::ST_DONE;
		result.removed_data     = '0;
		result.removed_priority = '0;
		if (req.opcode == spq_pkg::OP_ENQ) begin
			if (full) begin
				result.status = spq_pkg::ST_FULL;
			end
		end else if (empty) begin
			result.status = spq_pkg::ST_EMPTY;
		end else begin
			result.removed_data     = ent[0].data;
			result.removed_priority = ent[0].prio;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				if (!out_valid_q || out_fire) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_fire) begin
				out_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!out_valid_q || out_fire) begin
				out_q <= result;
			end else begin
				skid_q <= result;
			end
		end else if (out_fire && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// ----- rtl/spq_cell.sv -----
`timescale 1ns / 1ps
// one slot of the sorted chain: compare, hold, shift left or right
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic               occupied,
	input  spq_pkg::entry_t    new_entry,
	input  spq_pkg::entry_t    left_entry,
	input  logic               left_ge,
	input  spq_pkg::entry_t    right_entry,
	output spq_pkg::entry_t    entry,
	output logic               ge
);

	spq_pkg::entry_t entry_q;

	assign entry = entry_q;
	assign ge    = occupied && (entry_q.prio >= new_entry.prio);

	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (left_ge) begin
				entry_q <= left_entry;
			end else if (ge || !occupied) begin
				entry_q <= new_entry;
			end
		end else if (ctrl.deq) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ----- rtl/spq_checker.sv -----
`timescale 1ns / 1ps
// port-level checks for the sorted priority queue, bound to the top level
module spq_checker #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input spq_pkg::rsp_word_t rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W+spq_pkg::OCC_W-1:0] CAP_EXT = (CNT_W + spq_pkg::OCC_W)'(CAPACITY);

	a_stall_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid)
		else $error("req stalled with no result pending");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled rsp word changed");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == spq_pkg::ST_EMPTY) |->
			(rsp.occupancy == '0) && (rsp.removed_data == '0) &&
			(rsp.removed_priority == '0))
		else $error("empty status with nonzero fields");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == spq_pkg::ST_FULL) |->
			(rsp.occupancy == CAP_EXT[spq_pkg::OCC_W-1:0]) &&
			(rsp.removed_data == '0) && (rsp.removed_priority == '0))
		else $error("full status with wrong occupancy or data");

	a_no_stall_after_reset: assert property (@(posedge clk)
		!arst_n |=> !req_stall && !rsp_valid)
		else $error("output not cleared by reset");

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// ----- tb/sv/sorted_priority_queue_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the sorted priority queue: mirror queue, random and directed words
module sorted_priority_queue_tb;

	localparam int CAPACITY = spq_pkg::CAPACITY_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_WORDS = 1000;
	localparam int HOLD_CYCLES = 300;
	localparam logic signed [31:0] PRIO_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] PRIO_MAX = 32'sh7fff_ffff;

	class queue_mirror;
		logic signed [31:0] held_data [CAPACITY];
		logic signed [31:0] held_prio [CAPACITY];
		int held_count;
		spq_pkg::rsp_word_t expected_rsp [$];
		int errors;
		int n_enq;
		int n_deq;
		int n_full;
		int n_empty;
		int peak_count;

		function void note_request(spq_pkg::req_word_t w);
			spq_pkg::rsp_word_t r;
			int pos;
			int i;
			r = '0;
			r.status = spq_pkg::ST_DONE;
			if (w.opcode == spq_pkg::OP_ENQ) begin
				if (held_count >= CAPACITY) begin
					r.status = spq_pkg::ST_FULL;
					n_full++;
				end else begin
					pos = 0;
					while (pos < held_count &&
						$signed(held_prio[pos]) < $signed(w.entry_priority))
						pos++;
					for (i = held_count; i > pos; i--) begin
						held_data[i] = held_data[i-1];
						held_prio[i] = held_prio[i-1];
					end
					held_data[pos] = w.entry_data;
					held_prio[pos] = w.entry_priority;
					held_count++;
					n_enq++;
				end
			end else begin
				if (held_count == 0) begin
					r.status = spq_pkg::ST_EMPTY;
					n_empty++;
				end else begin
					r.removed_data = held_data[0];
					r.removed_priority = held_prio[0];
					for (i = 1; i < held_count; i++) begin
						held_data[i-1] = held_data[i];
						held_prio[i-1] = held_prio[i];
					end
					held_count--;
					n_deq++;
				end
			end
			if (held_count > peak_count)
				peak_count = held_count;
			r.occupancy = spq_pkg::OCC_W'(held_count);
			expected_rsp.push_back(r);
		endfunction

		function void check_response(spq_pkg::rsp_word_t got);
			spq_pkg::rsp_word_t want;
			if (expected_rsp.size() == 0) begin
				$error("response word with nothing expected: %p", got);
				errors++;
				return;
			end
			want = expected_rsp.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.removed_data !== want.removed_data) begin
				$error("removed_data: expected %0d, actual %0d",
					want.removed_data, got.removed_data);
				errors++;
			end
			if (got.removed_priority !== want.removed_priority) begin
				$error("removed_priority: expected %0d, actual %0d",
					want.removed_priority, got.removed_priority);
				errors++;
			end
			if (got.occupancy !== want.occupancy) begin
				$error("occupancy: expected %0d, actual %0d",
					want.occupancy, got.occupancy);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	spq_pkg::req_word_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	spq_pkg::rsp_word_t rsp;

	queue_mirror mirror = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_start = 1'b0;
	int hold_left = 0;
	int cycles = 0;
	int words_sent = 0;

	logic signed [31:0] fill_prio [16] = '{
		32'sd0, -32'sd1, PRIO_MAX, PRIO_MIN, 32'sd5, 32'sd5, 32'sd5, -32'sd7,
		32'sd100, PRIO_MIN, PRIO_MAX, 32'sd3, 32'sd3, -32'sd2, 32'sd0, 32'sd42
	};

	sorted_priority_queue #(.CAPACITY(CAPACITY)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[sorted_priority_queue] ERROR");
			$finish;
		end
	end

	// receiver: random stall, plus a long hold-off on request
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			mirror.check_response(rsp);
		if (hold_start) begin
			hold_left = HOLD_CYCLES;
			hold_start = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic send_word(input spq_pkg::req_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		mirror.note_request(w);
		words_sent++;
	endtask

	task automatic send_op(input spq_pkg::opcode_t op, input logic [31:0] dat,
		input logic [31:0] pri);
		spq_pkg::req_word_t w;
		w.opcode = op;
		w.entry_data = dat;
		w.entry_priority = pri;
		send_word(w);
	endtask

	function automatic logic [31:0] pick_priority();
		logic [31:0] p;
		case ($urandom_range(3))
			0: p = 32'($urandom_range(8)) - 32'd4;
			1: begin
				case ($urandom_range(3))
					0: p = PRIO_MIN;
					1: p = PRIO_MAX;
					2: p = '0;
					default: p = '1;
				endcase
			end
			default: p = $urandom;
		endcase
		return p;
	endfunction

	// bursts that lean toward filling, draining, or neither
	task automatic random_bursts(input int count);
		int done;
		int len;
		int enq_pct;
		int k;
		done = 0;
		while (done < count) begin
			len = $urandom_range(8, 40);
			case ($urandom_range(2))
				0: enq_pct = 80;
				1: enq_pct = 20;
				default: enq_pct = 50;
			endcase
			for (k = 0; k < len && done < count; k++) begin
				if ($urandom_range(99) < enq_pct)
					send_op(spq_pkg::OP_ENQ, $urandom, pick_priority());
				else
					send_op(spq_pkg::OP_DEQ, $urandom, $urandom);
				done++;
			end
		end
	endtask

	initial begin
		int i;
		int phase;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// empty dequeue with extreme ignored fields
		send_op(spq_pkg::OP_DEQ, 32'hffff_ffff, PRIO_MIN);
		// fill with extremes and ties
		for (i = 0; i < CAPACITY; i++) begin
			case (i)
				0: send_op(spq_pkg::OP_ENQ, 32'h7fff_ffff, fill_prio[i]);
				1: send_op(spq_pkg::OP_ENQ, 32'h8000_0000, fill_prio[i]);
				2: send_op(spq_pkg::OP_ENQ, 32'hffff_ffff, fill_prio[i]);
				3: send_op(spq_pkg::OP_ENQ, 32'h0000_0000, fill_prio[i]);
				default: send_op(spq_pkg::OP_ENQ, 32'h1000 + i, fill_prio[i]);
			endcase
		end
		// enqueue on a full queue
		send_op(spq_pkg::OP_ENQ, 32'hdead_beef, PRIO_MIN);
		for (i = 0; i < 4; i++)
			send_op(spq_pkg::OP_DEQ, 32'h0, 32'h0);

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 16;
					recv_idle_pct = 85;
				end
				1: begin
					send_idle_pct = 85;
					recv_idle_pct = 16;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (phase != 1)
				hold_start = 1'b1;
			random_bursts(RANDOM_WORDS / 3);
		end

		req_valid <= 1'b0;
		while (mirror.expected_rsp.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d words: %0d enqueues, %0d dequeues, %0d full, %0d empty",
			words_sent, mirror.n_enq, mirror.n_deq, mirror.n_full, mirror.n_empty);
		$display("peak occupancy %0d of %0d, %0d mismatches",
			mirror.peak_count, CAPACITY, mirror.errors);
		if (mirror.errors == 0 && mirror.expected_rsp.size() == 0) begin
			$display("[sorted_priority_queue] OK");
		end else begin
			$display("[sorted_priority_queue] ERROR");
		end
		$finish;
	end

endmodule
